### design/spcm_pkg.sv
package spcm_pkg;

    localparam int NUM_SECTORS      = 34;
    localparam int MAX_CHANNELS_DEF = 32;
    localparam int FULL_TURN        = 360;
    localparam int HALF_TURN        = 180;
    localparam int RANK_MAX         = 31;
    localparam int COUNT_MAX        = 63;

    localparam logic [5:0] LABEL_LFE1    = 6'd34;
    localparam logic [5:0] LABEL_LFE2    = 6'd35;
    localparam logic [5:0] LABEL_UNKNOWN = 6'd36;

    typedef struct packed {
        logic signed [9:0] azimuth_deg;
        logic signed [7:0] elevation_deg;
        logic              is_lfe;
        logic              last_channel;
    } spcm_in_t;

    typedef struct packed {
        logic [5:0] channel_label;
        logic [4:0] unknown_rank;
        logic [5:0] unknown_count;
        logic       reuse_error;
        logic       last_result;
    } spcm_out_t;

    typedef struct packed {
        logic       hit;
        logic [5:0] index;
    } spcm_match_t;

    typedef struct packed {
        logic signed [10:0] az_lo;
        logic signed [10:0] az_hi;
        logic signed [7:0]  el_lo;
        logic signed [7:0]  el_hi;
    } sector_t;

    localparam sector_t SECTOR_TAB [NUM_SECTORS] = '{
        '{-11'sd7,   11'sd7,    -8'sd9,  8'sd20},
        '{ 11'sd8,   11'sd22,   -8'sd9,  8'sd20},
        '{-11'sd22, -11'sd8,    -8'sd9,  8'sd20},
        '{ 11'sd23,  11'sd37,   -8'sd9,  8'sd20},
        '{-11'sd37, -11'sd23,   -8'sd9,  8'sd20},
        '{ 11'sd38,  11'sd52,   -8'sd9,  8'sd20},
        '{-11'sd52, -11'sd38,   -8'sd9,  8'sd20},
        '{ 11'sd53,  11'sd75,   -8'sd9,  8'sd20},
        '{-11'sd75, -11'sd53,   -8'sd9,  8'sd20},
        '{ 11'sd76,  11'sd100,  -8'sd45, 8'sd20},
        '{-11'sd100, -11'sd76,  -8'sd45, 8'sd20},
        '{ 11'sd101, 11'sd124,  -8'sd45, 8'sd20},
        '{-11'sd124, -11'sd101, -8'sd45, 8'sd20},
        '{ 11'sd125, 11'sd142,  -8'sd45, 8'sd20},
        '{-11'sd142, -11'sd125, -8'sd45, 8'sd20},
        '{ 11'sd143, 11'sd157,  -8'sd45, 8'sd20},
        '{-11'sd157, -11'sd143, -8'sd45, 8'sd20},
        '{ 11'sd158, -11'sd158, -8'sd45, 8'sd20},
        '{-11'sd10,  11'sd10,    8'sd21, 8'sd60},
        '{ 11'sd38,  11'sd66,    8'sd21, 8'sd60},
        '{-11'sd66, -11'sd38,    8'sd21, 8'sd60},
        '{ 11'sd11,  11'sd37,    8'sd21, 8'sd60},
        '{-11'sd37, -11'sd11,    8'sd21, 8'sd60},
        '{ 11'sd67,  11'sd100,   8'sd21, 8'sd60},
        '{-11'sd100, -11'sd67,   8'sd21, 8'sd60},
        '{ 11'sd101, 11'sd124,   8'sd21, 8'sd60},
        '{-11'sd124, -11'sd101,  8'sd21, 8'sd60},
        '{ 11'sd125, 11'sd157,   8'sd21, 8'sd60},
        '{-11'sd157, -11'sd125,  8'sd21, 8'sd60},
        '{ 11'sd158, -11'sd158,  8'sd21, 8'sd60},
        '{-11'sd180, 11'sd180,   8'sd61, 8'sd90},
        '{-11'sd10,  11'sd10,   -8'sd45, -8'sd10},
        '{ 11'sd11,  11'sd75,   -8'sd45, -8'sd10},
        '{-11'sd75, -11'sd11,   -8'sd45, -8'sd10}
    };

endpackage

### design/speaker_position_channel_matcher.sv
// Channel  | Direction | Handshake       | Item
// in       | input     | in_valid/stall  | spcm_in_t: one speaker of a layout
// out      | output    | out_valid/stall | spcm_out_t: label and layout status
// cfg      | input     | cfg_valid/ready | is_output_layout
//
// One item is taken per cycle while no stall on out holds the flow.
// The sector compares and the layout state update sit between the input
// register and the result register, so that single stage sets the rate.
// Reset clears both valid flags, the used mask, the unknown count and the error.
// A stall on out holds the result and backs up into in_stall once the
// input register is also full.
module speaker_position_channel_matcher
    import spcm_pkg::*;
#(
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  spcm_in_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output spcm_out_t out_data,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  logic      cfg_data
);

    spcm_in_t    in_reg;
    logic        in_valid_reg;
    spcm_out_t   out_reg;
    logic        out_valid_reg;
    logic        output_layout_reg;
    logic        advance;
    logic        take_in;
    spcm_match_t match;
    spcm_out_t   result;

    assign advance   = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_valid_reg && !advance;
    assign take_in   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    spcm_sector_match u_match
    (
        .azimuth_deg   (in_reg.azimuth_deg),
        .elevation_deg (in_reg.elevation_deg),
        .match         (match)
    );

    spcm_layout_state #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_state
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .step             (advance),
        .is_output_layout (output_layout_reg),
        .item             (in_reg),
        .match            (match),
        .result           (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            output_layout_reg <= 1'b0;
        end
        else
        begin
            if (take_in)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_valid && cfg_ready)
            begin
                output_layout_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            in_reg <= in_data;
        end
        if (advance)
        begin
            out_reg <= result;
        end
    end

endmodule

### design/spcm_sector_match.sv
module spcm_sector_match
    import spcm_pkg::*;
(
    input  logic signed [9:0] azimuth_deg,
    input  logic signed [7:0] elevation_deg,
    output spcm_match_t       match
);

    logic signed [10:0]     az_ext;
    logic signed [10:0]     az_wrap;
    logic [NUM_SECTORS-1:0] hit_vec;

    assign az_ext  = {azimuth_deg[9], azimuth_deg};
    assign az_wrap = azimuth_deg[9] ? (az_ext + 11'sd360) : az_ext;

    // A sector that starts on the positive side and ends on the negative side
    // spans the rear; it is tested with negative azimuths shifted up by a full turn.
    for (genvar i = 0; i < NUM_SECTORS; i++) begin : g_sector
        localparam logic signed [10:0] A0   = SECTOR_TAB[i].az_lo;
        localparam logic signed [10:0] A1   = SECTOR_TAB[i].az_hi;
        localparam bit                 WRAP = (A0 > 11'sd0) && (A1 < 11'sd0);
        localparam logic signed [10:0] A1E  = WRAP ? (A1 + 11'(FULL_TURN)) : A1;

        logic signed [10:0] az_cmp;

        assign az_cmp     = WRAP ? az_wrap : az_ext;
        assign hit_vec[i] = (az_cmp >= A0) && (az_cmp <= A1E)
                          && (elevation_deg >= SECTOR_TAB[i].el_lo)
                          && (elevation_deg <= SECTOR_TAB[i].el_hi);
    end

    // The highest matching sector wins.
    always_comb
    begin
        match.hit   = |hit_vec;
        match.index = '0;
        for (int i = 0; i < NUM_SECTORS; i++)
        begin
            if (hit_vec[i])
            begin
                match.index = 6'(i);
            end
        end
    end

endmodule

### design/spcm_layout_state.sv
module spcm_layout_state
    import spcm_pkg::*;
#(
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  logic        is_output_layout,
    input  spcm_in_t    item,
    input  spcm_match_t match,
    output spcm_out_t   result
);

    localparam int         LIMIT_INT = (MAX_CHANNELS < COUNT_MAX) ? MAX_CHANNELS : COUNT_MAX;
    localparam logic [5:0] UNK_LIMIT = 6'(LIMIT_INT);

    logic [NUM_SECTORS-1:0] mask_reg, mask_next;
    logic [5:0]             count_reg, count_next;
    logic                   error_reg, error_next;

    logic [NUM_SECTORS-1:0] sector_bit;
    logic signed [10:0]     az_ext;
    logic signed [10:0]     az_mod;
    logic                   lfe_one;

    assign az_ext = {item.azimuth_deg[9], item.azimuth_deg};

    // Remainder of the azimuth by a full turn, keeping the sign of the azimuth.
    always_comb
    begin
        if (az_ext >= 11'sd360)
        begin
            az_mod = az_ext - 11'sd360;
        end
        else if (az_ext <= -11'sd360)
        begin
            az_mod = az_ext + 11'sd360;
        end
        else
        begin
            az_mod = az_ext;
        end
    end

    assign lfe_one = ((az_mod >= 11'sd0) && (az_mod < 11'(HALF_TURN)))
                   || (az_mod < -11'(HALF_TURN));

    assign sector_bit = match.hit ? (NUM_SECTORS'(1) << match.index) : '0;

    always_comb
    begin
        mask_next            = mask_reg;
        count_next           = count_reg;
        error_next           = error_reg;
        result.channel_label = LABEL_UNKNOWN;
        result.unknown_rank  = '0;

        if (item.is_lfe)
        begin
            result.channel_label = lfe_one ? LABEL_LFE1 : LABEL_LFE2;
        end
        else if (match.hit)
        begin
            result.channel_label = match.index;
            if (((mask_reg & sector_bit) != '0) && is_output_layout)
            begin
                error_next = 1'b1;
            end
            mask_next = mask_reg | sector_bit;
        end
        else
        begin
            result.unknown_rank = (count_reg > 6'(RANK_MAX)) ? 5'(RANK_MAX) : count_reg[4:0];
            if (count_reg < UNK_LIMIT)
            begin
                count_next = count_reg + 6'd1;
            end
        end

        result.unknown_count = count_next;
        result.reuse_error   = error_next;
        result.last_result   = item.last_channel;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg  <= '0;
            count_reg <= '0;
            error_reg <= 1'b0;
        end
        else if (step)
        begin
            if (item.last_channel)
            begin
                mask_reg  <= '0;
                count_reg <= '0;
                error_reg <= 1'b0;
            end
            else
            begin
                mask_reg  <= mask_next;
                count_reg <= count_next;
                error_reg <= error_next;
            end
        end
    end

endmodule

### design/spcm_checker.sv
module spcm_checker
    import spcm_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_stall,
    input spcm_in_t  in_data,
    input logic      out_valid,
    input logic      out_stall,
    input spcm_out_t out_data,
    input logic      cfg_valid,
    input logic      cfg_ready,
    input logic      cfg_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("Stalled result item changed or vanished.");

    a_label_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.channel_label <= LABEL_UNKNOWN)
        else $error("Channel label out of range.");

    a_rank_only_unknown: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.unknown_rank != '0)
            |-> out_data.channel_label == LABEL_UNKNOWN)
        else $error("Unknown rank set on a known label.");

    a_unknown_counted: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.channel_label == LABEL_UNKNOWN)
            |-> out_data.unknown_count != '0)
        else $error("Unknown speaker not counted.");

    a_no_in_stall_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("Input stalled while the result register was free.");

endmodule

bind speaker_position_channel_matcher spcm_checker u_spcm_checker (.*);

### sim/tb_speaker_position_channel_matcher.sv
`timescale 1ns / 1ps

module tb_speaker_position_channel_matcher;
    import spcm_pkg::*;

    localparam int UNKNOWN_LIMIT = (MAX_CHANNELS_DEF < COUNT_MAX) ? MAX_CHANNELS_DEF : COUNT_MAX;
    localparam int LONG_HOLD_CYCLES = 200;
    localparam int LONG_HOLD_AT = 400;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    spcm_in_t  in_data = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    spcm_out_t out_data;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic      cfg_data = 1'b0;

    // Azimuth low, azimuth high, elevation low, elevation high for each sector.
    int sector_bounds [0:33][0:3] = '{
        '{-7, 7, -9, 20},       '{8, 22, -9, 20},       '{-22, -8, -9, 20},
        '{23, 37, -9, 20},      '{-37, -23, -9, 20},    '{38, 52, -9, 20},
        '{-52, -38, -9, 20},    '{53, 75, -9, 20},      '{-75, -53, -9, 20},
        '{76, 100, -45, 20},    '{-100, -76, -45, 20},  '{101, 124, -45, 20},
        '{-124, -101, -45, 20}, '{125, 142, -45, 20},   '{-142, -125, -45, 20},
        '{143, 157, -45, 20},   '{-157, -143, -45, 20}, '{158, -158, -45, 20},
        '{-10, 10, 21, 60},     '{38, 66, 21, 60},      '{-66, -38, 21, 60},
        '{11, 37, 21, 60},      '{-37, -11, 21, 60},    '{67, 100, 21, 60},
        '{-100, -67, 21, 60},   '{101, 124, 21, 60},    '{-124, -101, 21, 60},
        '{125, 157, 21, 60},    '{-157, -125, 21, 60},  '{158, -158, 21, 60},
        '{-180, 180, 61, 90},   '{-10, 10, -45, -10},   '{11, 75, -45, -10},
        '{-75, -11, -45, -10}
    };

    logic [33:0] used_labels = '0;
    int          unknown_total = 0;
    logic        reuse_seen = 1'b0;
    logic        output_layout = 1'b0;

    spcm_in_t    speaker_q [$];
    spcm_out_t   label_expect_q [$];
    int unsigned pushed_cnt = 0;
    int unsigned accepted_cnt = 0;
    int unsigned label_errors = 0;
    logic        in_fire = 1'b0;
    int          gap_left = 0;
    int          stall_left = 0;
    logic        long_hold_done = 1'b0;
    logic        calm = 1'b0;

    speaker_position_channel_matcher uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic spcm_out_t match_speaker(spcm_in_t spk);
        spcm_out_t res;
        int az, el, r, a, a_hi, hit, k;
        az = $signed(spk.azimuth_deg);
        el = $signed(spk.elevation_deg);
        res = '0;
        if (spk.is_lfe)
        begin
            r = (az >= 0) ? az % 360 : -((-az) % 360);
            if ((r >= 0 && r < 180) || (r < -180 && r >= -360))
                res.channel_label = LABEL_LFE1;
            else
                res.channel_label = LABEL_LFE2;
        end
        else
        begin
            hit = -1;
            for (k = 0; k < 34; k++)
            begin
                a = az;
                a_hi = sector_bounds[k][1];
                if (sector_bounds[k][0] > 0 && a_hi < 0)
                begin
                    a_hi += 360;
                    if (a < 0)
                        a += 360;
                end
                if (a >= sector_bounds[k][0] && a <= a_hi &&
                    el >= sector_bounds[k][2] && el <= sector_bounds[k][3])
                    hit = k;
            end
            if (hit >= 0)
            begin
                if (used_labels[hit] && output_layout)
                    reuse_seen = 1'b1;
                used_labels[hit] = 1'b1;
                res.channel_label = hit[5:0];
            end
            else
            begin
                res.channel_label = LABEL_UNKNOWN;
                res.unknown_rank = (unknown_total > 31) ? 5'd31 : unknown_total[4:0];
                if (unknown_total < UNKNOWN_LIMIT)
                    unknown_total++;
            end
        end
        res.unknown_count = unknown_total[5:0];
        res.reuse_error = reuse_seen;
        res.last_result = spk.last_channel;
        if (spk.last_channel)
        begin
            used_labels = '0;
            unknown_total = 0;
            reuse_seen = 1'b0;
        end
        return res;
    endfunction

    task automatic push_speaker(input int az, input int el, input bit lfe, input bit last);
        spcm_in_t spk;
        spk.azimuth_deg = az[9:0];
        spk.elevation_deg = el[7:0];
        spk.is_lfe = lfe;
        spk.last_channel = last;
        speaker_q.push_back(spk);
        pushed_cnt++;
    endtask

    // A crowded layout is long and mostly unknown so that the counts saturate.
    task automatic push_layout(input int n, input bit crowded);
        int az, el, k, s, pick, lo, hi;
        bit lfe, last;
        for (k = 0; k < n; k++)
        begin
            pick = $urandom_range(0, 99);
            lfe = 1'b0;
            if (crowded && pick < 85)
            begin
                az = $urandom_range(0, 720) - 360;
                el = $urandom_range(0, 44) - 90;
            end
            else if (pick < 70)
            begin
                s = $urandom_range(0, 33);
                lo = sector_bounds[s][0];
                hi = sector_bounds[s][1];
                if (lo > 0 && hi < 0)
                    hi += 360;
                case ($urandom_range(0, 3))
                    0: az = lo;
                    1: az = hi;
                    default: az = lo + $urandom_range(0, hi - lo);
                endcase
                if (az > 180)
                    az -= 360;
                lo = sector_bounds[s][2];
                hi = sector_bounds[s][3];
                case ($urandom_range(0, 3))
                    0: el = lo;
                    1: el = hi;
                    default: el = lo + $urandom_range(0, hi - lo);
                endcase
            end
            else if (pick < 80)
            begin
                lfe = 1'b1;
                az = $urandom_range(0, 720) - 360;
                el = $urandom_range(0, 180) - 90;
            end
            else if (pick < 95)
            begin
                az = $urandom_range(0, 720) - 360;
                el = $urandom_range(0, 180) - 90;
            end
            else
            begin
                az = $urandom_range(0, 1023) - 512;
                el = $urandom_range(0, 255) - 128;
            end
            last = (k == n - 1) || (!crowded && $urandom_range(0, 49) == 0);
            push_speaker(az, el, lfe, last);
        end
    endtask

    task automatic push_random_phase(input int target);
        int made, n;
        made = 0;
        while (made < target)
        begin
            if ($urandom_range(0, 29) == 0)
            begin
                n = 45 + $urandom_range(0, 5);
                push_layout(n, 1'b1);
            end
            else
            begin
                n = 1 + $urandom_range(0, 11);
                push_layout(n, 1'b0);
            end
            made += n;
        end
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (accepted_cnt != pushed_cnt || label_expect_q.size() != 0);
    endtask

    task automatic write_layout_mode(input logic mode);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= mode;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    always @(negedge clk)
    begin
        if (!in_valid || in_fire)
        begin
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                in_valid <= 1'b0;
            end
            else if (speaker_q.size() == 0)
                in_valid <= 1'b0;
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                gap_left <= $urandom_range(0, 15);
                in_valid <= 1'b0;
            end
            else
            begin
                in_data <= speaker_q.pop_front();
                in_valid <= 1'b1;
            end
        end
    end

    always @(negedge clk)
    begin
        if (!long_hold_done && accepted_cnt >= LONG_HOLD_AT)
        begin
            long_hold_done <= 1'b1;
            stall_left <= LONG_HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_stall <= 1'b1;
        end
        else if (!calm && $urandom_range(0, 9) == 0)
        begin
            stall_left <= $urandom_range(0, 15);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        spcm_out_t want;
        in_fire <= in_valid && !in_stall;
        if (cfg_valid && cfg_ready)
            output_layout = cfg_data;
        if (in_valid && !in_stall)
        begin
            label_expect_q.push_back(match_speaker(in_data));
            accepted_cnt++;
        end
        if (out_valid && !out_stall)
        begin
            if (label_expect_q.size() == 0)
            begin
                label_errors++;
                if (label_errors <= 10)
                    $display("unexpected item: label %0d rank %0d count %0d err %0b last %0b",
                             out_data.channel_label, out_data.unknown_rank,
                             out_data.unknown_count, out_data.reuse_error,
                             out_data.last_result);
            end
            else
            begin
                want = label_expect_q.pop_front();
                if (out_data.channel_label !== want.channel_label ||
                    out_data.unknown_rank !== want.unknown_rank ||
                    out_data.unknown_count !== want.unknown_count ||
                    out_data.reuse_error !== want.reuse_error ||
                    out_data.last_result !== want.last_result)
                begin
                    label_errors++;
                    if (label_errors <= 10)
                    begin
                        $display("mismatch: expected label %0d rank %0d count %0d err %0b last %0b",
                                 want.channel_label, want.unknown_rank, want.unknown_count,
                                 want.reuse_error, want.last_result);
                        $display("          got label %0d rank %0d count %0d err %0b last %0b",
                                 out_data.channel_label, out_data.unknown_rank,
                                 out_data.unknown_count, out_data.reuse_error,
                                 out_data.last_result);
                    end
                end
            end
        end
    end

    initial
    begin
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        // Output layout: reuse, unknowns, LFE sign rule, rear wrap and field extremes.
        write_layout_mode(1'b1);
        push_speaker(0, 0, 1'b0, 1'b0);
        push_speaker(0, 0, 1'b0, 1'b0);
        push_speaker(30, -90, 1'b0, 1'b0);
        push_speaker(0, 0, 1'b1, 1'b0);
        push_speaker(179, 0, 1'b1, 1'b0);
        push_speaker(180, 0, 1'b1, 1'b0);
        push_speaker(-180, 0, 1'b1, 1'b0);
        push_speaker(-181, 0, 1'b1, 1'b0);
        push_speaker(360, 0, 1'b1, 1'b0);
        push_speaker(-360, 0, 1'b1, 1'b0);
        push_speaker(-200, 0, 1'b0, 1'b0);
        push_speaker(180, 30, 1'b0, 1'b0);
        push_speaker(-180, 90, 1'b0, 1'b0);
        push_speaker(511, 127, 1'b0, 1'b0);
        push_speaker(-512, -128, 1'b0, 1'b1);
        push_speaker(0, 0, 1'b0, 1'b1);
        wait_drained();

        // Input layout: the same label twice raises no error.
        write_layout_mode(1'b0);
        push_speaker(0, 0, 1'b0, 1'b0);
        push_speaker(0, 0, 1'b0, 1'b0);
        push_speaker(-158, -45, 1'b0, 1'b0);
        push_speaker(158, 20, 1'b0, 1'b0);
        push_speaker(360, 90, 1'b0, 1'b0);
        push_speaker(-360, -90, 1'b0, 1'b1);
        wait_drained();

        write_layout_mode(1'b1);
        push_random_phase(700);
        wait_drained();

        write_layout_mode(1'b0);
        push_random_phase(700);
        wait_drained();

        write_layout_mode(1'b1);
        calm = 1'b1;
        push_random_phase(500);
        wait_drained();

        repeat (10) @(posedge clk);
        if (label_errors == 0 && label_expect_q.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

### sim.f
design/spcm_pkg.sv
design/spcm_sector_match.sv
design/spcm_layout_state.sv
design/speaker_position_channel_matcher.sv
design/spcm_checker.sv
sim/tb_speaker_position_channel_matcher.sv
